// ===== rtl/gfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gfp_pkg
// Types and constants shared by the gradient fill pixel pipeline.
// ----------------------------------------------------------------------------
package gfp_pkg;

   localparam int unsigned PIXEL_COORD_BITS = 12;
   localparam int unsigned T_FRAC_BITS_DEF  = 16;

   // Working width of the squared lengths, the dot product and the divider.
   localparam int unsigned DIV_W = 36;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_X       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_Y       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COLOR = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_COLOR   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE        = 3'd6;

   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_RADIAL = 1'b1;

   typedef enum logic [1:0] {
      TSEL_CALC,
      TSEL_ZERO,
      TSEL_ONE
   } gfp_tsel_type;

   typedef struct packed {
      logic         valid;
      gfp_tsel_type tsel;
   } gfp_ctl_type;

   typedef struct packed {
      logic [PIXEL_COORD_BITS-1:0] pixel_x;
      logic [PIXEL_COORD_BITS-1:0] pixel_y;
   } gfp_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } gfp_rsp_type;

endpackage

// ===== rtl/gfp_div_pipe.sv =====
// ----------------------------------------------------------------------------
// gfp_div_pipe
// Pipelined restoring divider, one quotient bit per stage:
// q = floor(num * 2^Q_BITS / den) for num < den.
// ----------------------------------------------------------------------------
module gfp_div_pipe #(
   parameter int unsigned Q_BITS = 2 * gfp_pkg::T_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gfp_pkg::gfp_ctl_type      in_ctl,
   input  logic [gfp_pkg::DIV_W-1:0] in_num,
   input  logic [gfp_pkg::DIV_W-1:0] in_den,
   output gfp_pkg::gfp_ctl_type      out_ctl,
   output logic [Q_BITS-1:0]         out_q
);
   import gfp_pkg::*;

   gfp_ctl_type        ctl_ff [0:Q_BITS-1];
   logic [DIV_W-1:0]   rem_ff [0:Q_BITS-1];
   logic [DIV_W-1:0]   den_ff [0:Q_BITS-1];
   logic [Q_BITS-1:0]  q_ff   [0:Q_BITS-1];

   for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
      gfp_ctl_type       ctl_cur;
      logic [DIV_W-1:0]  rem_cur;
      logic [DIV_W-1:0]  den_cur;
      logic [Q_BITS-1:0] q_cur;
      logic [DIV_W-1:0]  rem_sh;
      logic              ge;
      logic [DIV_W-1:0]  rem_in;
      logic [Q_BITS-1:0] q_in;

      if (i == 0) begin : g_first
         assign ctl_cur = in_ctl;
         assign rem_cur = in_num;
         assign den_cur = in_den;
         assign q_cur   = '0;
      end else begin : g_next
         assign ctl_cur = ctl_ff[i-1];
         assign rem_cur = rem_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign q_cur   = q_ff[i-1];
      end

      assign rem_sh = {rem_cur[DIV_W-2:0], 1'b0};
      assign ge     = (rem_sh >= den_cur);
      assign rem_in = ge ? (rem_sh - den_cur) : rem_sh;
      assign q_in   = {q_cur[Q_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '{valid: 1'b0, tsel: TSEL_ZERO};
         end else begin
            ctl_ff[i] <= ctl_cur;
         end
         rem_ff[i] <= rem_in;
         den_ff[i] <= den_cur;
         q_ff[i]   <= q_in;
      end
   end

   assign out_ctl = ctl_ff[Q_BITS-1];
   assign out_q   = q_ff[Q_BITS-1];

endmodule

// ===== rtl/gfp_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// gfp_sqrt_pipe
// Pipelined digit-by-digit integer square root, one root bit per stage.
// The upper half of the radicand rides along as the linear-mode fraction.
// ----------------------------------------------------------------------------
module gfp_sqrt_pipe #(
   parameter int unsigned T_BITS = gfp_pkg::T_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gfp_pkg::gfp_ctl_type  in_ctl,
   input  logic [2*T_BITS-1:0]   in_q,
   output gfp_pkg::gfp_ctl_type  out_ctl,
   output logic [T_BITS-1:0]     out_root,
   output logic [T_BITS-1:0]     out_lin
);
   import gfp_pkg::*;

   gfp_ctl_type         ctl_ff  [0:T_BITS-1];
   logic [2*T_BITS-1:0] v_ff    [0:T_BITS-1];
   logic [T_BITS:0]     rem_ff  [0:T_BITS-1];
   logic [T_BITS-1:0]   root_ff [0:T_BITS-1];
   logic [T_BITS-1:0]   lin_ff  [0:T_BITS-1];

   for (genvar j = 0; j < T_BITS; j++) begin : g_stage
      gfp_ctl_type         ctl_cur;
      logic [2*T_BITS-1:0] v_cur;
      logic [T_BITS:0]     rem_cur;
      logic [T_BITS-1:0]   root_cur;
      logic [T_BITS-1:0]   lin_cur;
      logic [T_BITS+1:0]   rem_sh;
      logic [T_BITS+1:0]   trial;
      logic                ge;
      logic [T_BITS+1:0]   rem_diff;

      if (j == 0) begin : g_first
         assign ctl_cur  = in_ctl;
         assign v_cur    = in_q;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign lin_cur  = in_q[2*T_BITS-1:T_BITS];
      end else begin : g_next
         assign ctl_cur  = ctl_ff[j-1];
         assign v_cur    = v_ff[j-1];
         assign rem_cur  = rem_ff[j-1];
         assign root_cur = root_ff[j-1];
         assign lin_cur  = lin_ff[j-1];
      end

      // The partial remainder stays at or below twice the partial root.
      assign rem_sh   = {rem_cur[T_BITS-1:0], v_cur[2*T_BITS-1:2*T_BITS-2]};
      assign trial    = {root_cur, 2'b01};
      assign ge       = (rem_sh >= trial);
      assign rem_diff = ge ? (rem_sh - trial) : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '{valid: 1'b0, tsel: TSEL_ZERO};
         end else begin
            ctl_ff[j] <= ctl_cur;
         end
         v_ff[j]    <= {v_cur[2*T_BITS-3:0], 2'b00};
         rem_ff[j]  <= rem_diff[T_BITS:0];
         root_ff[j] <= {root_cur[T_BITS-2:0], ge};
         lin_ff[j]  <= lin_cur;
      end
   end

   assign out_ctl  = ctl_ff[T_BITS-1];
   assign out_root = root_ff[T_BITS-1];
   assign out_lin  = lin_ff[T_BITS-1];

endmodule

// ===== rtl/gradient_fill_pixel_top.sv =====
// ----------------------------------------------------------------------------
// gradient_fill_pixel_top
// Linear and radial gradient fill: one pixel coordinate in, one RGBA color out.
// ----------------------------------------------------------------------------
//  Channel   Ports                              Direction  Handshake
//  request   start, busy, req                   in         start & !busy
//  result    rsp_valid, rsp                     out        one-cycle strobe
//  config    csr_valid, csr_ready, csr_index,   in         valid & ready
//            csr_data
//
// One request enters per clock; busy is never raised. Each result passes
// through four setup stages, one divider stage per quotient bit
// (2*T_FRAC_BITS), one square-root stage per fraction bit, then three
// blend stages.
// Reset is synchronous and clears every valid bit and the configuration registers.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
module gradient_fill_pixel_top #(
   parameter int unsigned T_FRAC_BITS = gfp_pkg::T_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gfp_pkg::gfp_req_type            req,
   output logic                            rsp_valid,
   output gfp_pkg::gfp_rsp_type            rsp,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gfp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gfp_pkg::*;

   localparam int unsigned Q_BITS = 2 * T_FRAC_BITS;
   localparam int unsigned LAT    = 7 + Q_BITS + T_FRAC_BITS;
   localparam int unsigned PW     = T_FRAC_BITS + 9;

   // Configuration registers.
   logic signed [15:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [31:0]        start_color_ff, end_color_ff;
   logic               mode_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         end_x_ff       <= '0;
         end_y_ff       <= '0;
         start_color_ff <= '0;
         end_color_ff   <= '0;
         mode_ff        <= MODE_LINEAR;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_X:     start_x_ff     <= csr_data[15:0];
            CSR_START_Y:     start_y_ff     <= csr_data[15:0];
            CSR_END_X:       end_x_ff       <= csr_data[15:0];
            CSR_END_Y:       end_y_ff       <= csr_data[15:0];
            CSR_START_COLOR: start_color_ff <= csr_data;
            CSR_END_COLOR:   end_color_ff   <= csr_data;
            CSR_MODE:        mode_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Stage 0: differences.
   logic               v0_ff;
   logic signed [17:0] px_ff, py_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic signed [17:0] px_in, py_in;
   logic signed [16:0] dx_in, dy_in;

   assign px_in = $signed({{(18-PIXEL_COORD_BITS){1'b0}}, req.pixel_x})
                  - 18'(start_x_ff);
   assign py_in = $signed({{(18-PIXEL_COORD_BITS){1'b0}}, req.pixel_y})
                  - 18'(start_y_ff);
   assign dx_in = 17'(end_x_ff) - 17'(start_x_ff);
   assign dy_in = 17'(end_y_ff) - 17'(start_y_ff);

   // Stage 1: products.
   logic               v1_ff;
   logic signed [35:0] pdx_ff, pdy_ff, ppx_ff, ppy_ff, ddx_ff, ddy_ff;

   // Stage 2: sums.
   logic               v2_ff;
   logic signed [DIV_W-1:0] dot_ff;
   logic [DIV_W-1:0]   dist2_ff, len2_ff;

   // Stage 3: classification and divider operands.
   gfp_ctl_type        c3_ff, c3_in;
   logic [DIV_W-1:0]   num_ff, num_in, den_ff;

   always_comb begin
      c3_in  = '{valid: v2_ff, tsel: TSEL_CALC};
      num_in = '0;
      if (len2_ff == '0) begin
         c3_in.tsel = TSEL_ZERO;
      end else if (mode_ff == MODE_LINEAR) begin
         if (dot_ff <= 0) begin
            c3_in.tsel = TSEL_ZERO;
         end else if (DIV_W'(dot_ff) >= len2_ff) begin
            c3_in.tsel = TSEL_ONE;
         end else begin
            num_in = DIV_W'(dot_ff);
         end
      end else begin
         if (dist2_ff >= len2_ff) begin
            c3_in.tsel = TSEL_ONE;
         end else begin
            num_in = dist2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         c3_ff <= '{valid: 1'b0, tsel: TSEL_ZERO};
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         c3_ff <= c3_in;
      end
      px_ff    <= px_in;
      py_ff    <= py_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      pdx_ff   <= 36'(px_ff * dx_ff);
      pdy_ff   <= 36'(py_ff * dy_ff);
      ppx_ff   <= 36'(px_ff * px_ff);
      ppy_ff   <= 36'(py_ff * py_ff);
      ddx_ff   <= 36'(dx_ff * dx_ff);
      ddy_ff   <= 36'(dy_ff * dy_ff);
      dot_ff   <= pdx_ff + pdy_ff;
      dist2_ff <= DIV_W'(ppx_ff + ppy_ff);
      len2_ff  <= DIV_W'(ddx_ff + ddy_ff);
      num_ff   <= num_in;
      den_ff   <= len2_ff;
   end

   // Divider and square root.
   gfp_ctl_type             div_ctl, sq_ctl;
   logic [Q_BITS-1:0]       div_q;
   logic [T_FRAC_BITS-1:0]  sq_root, sq_lin;

   gfp_div_pipe #(.Q_BITS(Q_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (c3_ff),
      .in_num  (num_ff),
      .in_den  (den_ff),
      .out_ctl (div_ctl),
      .out_q   (div_q)
   );

   gfp_sqrt_pipe #(.T_BITS(T_FRAC_BITS)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (div_ctl),
      .in_q     (div_q),
      .out_ctl  (sq_ctl),
      .out_root (sq_root),
      .out_lin  (sq_lin)
   );

   // Fraction select.
   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   logic                  tv_ff;
   gfp_tsel_type          ts_ff;
   logic [T_FRAC_BITS:0]  t_ff, t_in;

   always_comb begin
      case (sq_ctl.tsel)
         TSEL_CALC: t_in = (mode_ff == MODE_RADIAL) ? {1'b0, sq_root} : {1'b0, sq_lin};
         TSEL_ONE:  t_in = T_ONE;
         default:   t_in = '0;
      endcase
   end

   // Blend: products, then sum and truncate.
   logic                 pv_ff;
   logic [PW-1:0]        pa_ff [0:3];
   logic [PW-1:0]        pb_ff [0:3];
   logic [7:0]           ch_in [0:3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ch_in[k] = 8'((pa_ff[k] + pb_ff[k]) >> T_FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff     <= 1'b0;
         pv_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         tv_ff     <= sq_ctl.valid;
         pv_ff     <= tv_ff;
         rsp_valid <= pv_ff;
      end
      ts_ff <= sq_ctl.tsel;
      t_ff  <= t_in;
      for (int k = 0; k < 4; k++) begin
         pa_ff[k] <= PW'(start_color_ff[24-8*k +: 8] * (T_ONE - t_ff));
         pb_ff[k] <= PW'(end_color_ff[24-8*k +: 8] * t_ff);
      end
      rsp.red   <= ch_in[0];
      rsp.green <= ch_in[1];
      rsp.blue  <= ch_in[2];
      rsp.alpha <= ch_in[3];
   end

   // Every request is followed by a strobe once it has passed through the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result strobe missing after pipeline latency");

   a_t_one: assert property (@(posedge clock) disable iff (reset)
      (tv_ff && ts_ff == TSEL_ONE) |-> (t_ff == T_ONE))
      else $error("saturated pixel did not get t of one");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (tv_ff && ts_ff == TSEL_ZERO) |-> (t_ff == '0))
      else $error("pixel before start did not get t of zero");

endmodule
